// ===== src/fbpa_pkg.sv =====
// Shared constants, codes and types of the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_CHUNKS  = 256;
  localparam int INDEX_SPACE = 256;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int POOL_LIMIT  = (MAX_CHUNKS < INDEX_SPACE) ? MAX_CHUNKS : INDEX_SPACE;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] CHUNK_COUNT_RST = CNT_W'(256);
  localparam logic [CNT_W-1:0] WARN_LEVEL_RST  = CNT_W'(231);

  localparam logic REG_CHUNK_COUNT = 1'b0;
  localparam logic REG_WARN_LEVEL  = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_EXHAUSTED = 2'd1;
  localparam status_t STATUS_DOUBLE    = 2'd2;
  localparam status_t STATUS_RANGE     = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// ===== src/fbpa_req_if.sv =====
// Request channel: kind and chunk index under a valid/ready handshake.
interface fbpa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [fbpa_pkg::IDX_W-1:0] chunk_index;

  modport source (output valid, kind, chunk_index, input ready);
  modport sink   (input valid, kind, chunk_index, output ready);
endinterface

// ===== src/fbpa_rsp_if.sv =====
// Result channel: status, granted chunk and counts under a valid/ready handshake.
interface fbpa_rsp_if;
  logic                       valid;
  logic                       ready;
  fbpa_pkg::status_t          status;
  logic [fbpa_pkg::IDX_W-1:0] granted_index;
  logic [fbpa_pkg::CNT_W-1:0] live_count;
  logic [fbpa_pkg::CNT_W-1:0] peak_count;
  logic                       near_full;

  modport source (output valid, status, granted_index, live_count, peak_count, near_full,
                  input ready);
  modport sink   (input valid, status, granted_index, live_count, peak_count, near_full,
                  output ready);
endinterface

// ===== src/fbpa_ctrl.sv =====
// Controller: request handshake, execute sequencing and result beat valid.
module fbpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output fbpa_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/fbpa_dpath.sv =====
// Datapath: free stack, link memory, allocated bits, counters and result register.
module fbpa_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbpa_pkg::cmd_t             cmd,
  input  logic                       in_kind,
  input  logic [fbpa_pkg::IDX_W-1:0] in_chunk_index,
  input  logic [fbpa_pkg::CNT_W-1:0] chunk_count,
  input  logic [fbpa_pkg::CNT_W-1:0] warn_level,
  output fbpa_pkg::status_t          out_status,
  output logic [fbpa_pkg::IDX_W-1:0] out_granted_index,
  output logic [fbpa_pkg::CNT_W-1:0] out_live_count,
  output logic [fbpa_pkg::CNT_W-1:0] out_peak_count,
  output logic                       out_near_full
);

  localparam logic [fbpa_pkg::CNT_W-1:0] LIMIT = fbpa_pkg::CNT_W'(fbpa_pkg::POOL_LIMIT);
  localparam logic [fbpa_pkg::CNT_W-1:0] ONE   = fbpa_pkg::CNT_W'(1);

  logic [fbpa_pkg::IDX_W-1:0] link_mem [fbpa_pkg::INDEX_SPACE];
  logic [fbpa_pkg::IDX_W-1:0] link_rdata_r;

  logic                             kind_r;
  logic [fbpa_pkg::IDX_W-1:0]       idx_r;
  logic [fbpa_pkg::INDEX_SPACE-1:0] alloc_r, alloc_nxt;
  logic [fbpa_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic                             stack_ne_r, stack_ne_nxt;
  logic [fbpa_pkg::CNT_W-1:0]       fresh_r, fresh_nxt;
  logic [fbpa_pkg::CNT_W-1:0]       live_r, live_nxt;
  logic [fbpa_pkg::CNT_W-1:0]       peak_r, peak_nxt;

  fbpa_pkg::status_t          status;
  logic [fbpa_pkg::IDX_W-1:0] granted;
  logic                       warn;
  logic [fbpa_pkg::CNT_W-1:0] size;
  logic                       link_we;

  assign size = (chunk_count > LIMIT) ? LIMIT : chunk_count;

  always_comb begin
    alloc_nxt = alloc_r;
    head_nxt  = head_r;
    fresh_nxt = fresh_r;
    live_nxt  = live_r;
    peak_nxt  = peak_r;
    status    = fbpa_pkg::STATUS_OK;
    granted   = '0;
    warn      = 1'b0;
    link_we   = 1'b0;
    if (kind_r == fbpa_pkg::KIND_ALLOC) begin
      if (live_r < size && stack_ne_r) begin
        granted  = head_r;
        head_nxt = link_rdata_r;
      end else if (live_r < size && fresh_r < size) begin
        granted   = fresh_r[fbpa_pkg::IDX_W-1:0];
        fresh_nxt = fresh_r + ONE;
      end else begin
        status = fbpa_pkg::STATUS_EXHAUSTED;
      end
      if (status == fbpa_pkg::STATUS_OK) begin
        alloc_nxt[granted] = 1'b1;
        live_nxt           = live_r + ONE;
        if (live_nxt > peak_r) begin
          peak_nxt = live_nxt;
        end
        warn = (live_nxt >= warn_level);
      end
    end else begin
      if ({1'b0, idx_r} >= size) begin
        status = fbpa_pkg::STATUS_RANGE;
      end else if (!alloc_r[idx_r] || live_r == '0) begin
        status = fbpa_pkg::STATUS_DOUBLE;
      end else begin
        alloc_nxt[idx_r] = 1'b0;
        link_we          = 1'b1;
        head_nxt         = idx_r;
        live_nxt         = live_r - ONE;
      end
    end
    stack_ne_nxt = (fresh_nxt > live_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && link_we) begin
      link_mem[idx_r] <= head_r;
    end
    link_rdata_r <= link_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      idx_r  <= in_chunk_index;
    end
    if (cmd.exec) begin
      out_status        <= status;
      out_granted_index <= granted;
      out_live_count    <= live_nxt;
      out_peak_count    <= peak_nxt;
      out_near_full     <= warn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r    <= '0;
      head_r     <= '0;
      stack_ne_r <= 1'b0;
      fresh_r    <= '0;
      live_r     <= '0;
      peak_r     <= '0;
    end else if (cmd.exec) begin
      alloc_r    <= alloc_nxt;
      head_r     <= head_nxt;
      stack_ne_r <= stack_ne_nxt;
      fresh_r    <= fresh_nxt;
      live_r     <= live_nxt;
      peak_r     <= peak_nxt;
    end
  end

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: config registers, controller, datapath.
//
//   channel | direction | beat contents
//   --------+-----------+-------------------------------------------------------
//   in_if   | sink      | kind, chunk_index
//   out_if  | source    | status, granted_index, live_count, peak_count, near_full
//   apb     | slave     | reg 0 chunk_count at 0x0, reg 1 warn_level at 0x4
//
// A request is accepted, then executed; the split is set by the registered read of
// the link memory at the free stack head. One request is in flight at a time.
// A finished result waits in the output register; the next request is accepted
// meanwhile and its execute cycle holds until that result is taken.
// Reset is synchronous, active low; no clearing pass is needed.
module fixed_block_pool_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  fbpa_req_if.sink                    in_if,
  fbpa_rsp_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbpa_pkg::ADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::DATA_W-1:0] pwdata,
  output logic [fbpa_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [fbpa_pkg::CNT_W-1:0] chunk_count_r;
  logic [fbpa_pkg::CNT_W-1:0] warn_level_r;
  logic                       cfg_we;
  fbpa_pkg::cmd_t             cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_count_r <= fbpa_pkg::CHUNK_COUNT_RST;
      warn_level_r  <= fbpa_pkg::WARN_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        fbpa_pkg::REG_CHUNK_COUNT: chunk_count_r <= pwdata[fbpa_pkg::CNT_W-1:0];
        fbpa_pkg::REG_WARN_LEVEL:  warn_level_r  <= pwdata[fbpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fbpa_pkg::REG_CHUNK_COUNT: prdata = fbpa_pkg::DATA_W'(chunk_count_r);
      fbpa_pkg::REG_WARN_LEVEL:  prdata = fbpa_pkg::DATA_W'(warn_level_r);
      default:                   prdata = '0;
    endcase
  end

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  fbpa_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_if.kind),
    .in_chunk_index    (in_if.chunk_index),
    .chunk_count       (chunk_count_r),
    .warn_level        (warn_level_r),
    .out_status        (out_if.status),
    .out_granted_index (out_if.granted_index),
    .out_live_count    (out_if.live_count),
    .out_peak_count    (out_if.peak_count),
    .out_near_full     (out_if.near_full)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("request accepted while previous request still executing");

  a_live_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.live_count <= out_if.peak_count)
    else $error("live count above peak count");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status != fbpa_pkg::STATUS_OK
      |-> out_if.granted_index == '0 && !out_if.near_full)
    else $error("failed request carries a grant or warning");

  a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_if.valid)
    else $error("execute cycle did not load a result beat");

endmodule

// ===== tb/tb_pool_checker.sv =====
// Checker for the fixed block pool allocator: predicts each result beat and compares it.
module tb_pool_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  fbpa_req_if                         req_mon,
  fbpa_rsp_if                         rsp_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbpa_pkg::ADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::DATA_W-1:0] pwdata,
  input  logic [fbpa_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  output int unsigned                 n_fail,
  output int unsigned                 n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [fbpa_pkg::CNT_W-1:0] ONE = fbpa_pkg::CNT_W'(1);

  typedef struct packed {
    fbpa_pkg::status_t          status;
    logic [fbpa_pkg::IDX_W-1:0] granted;
    logic [fbpa_pkg::CNT_W-1:0] live;
    logic [fbpa_pkg::CNT_W-1:0] peak;
    logic                       near;
  } pool_result_t;

  logic [fbpa_pkg::CNT_W-1:0] cfg_chunks;
  logic [fbpa_pkg::CNT_W-1:0] cfg_warn;

  logic [fbpa_pkg::IDX_W-1:0] link_mem [fbpa_pkg::INDEX_SPACE];
  logic                       taken_bit [fbpa_pkg::INDEX_SPACE];
  logic [fbpa_pkg::IDX_W-1:0] stack_top;
  logic                       stacked;
  logic [fbpa_pkg::CNT_W-1:0] fresh_ptr;
  logic [fbpa_pkg::CNT_W-1:0] live_cnt;
  logic [fbpa_pkg::CNT_W-1:0] peak_cnt;

  pool_result_t     awaited_q [$];
  pool_result_t     want;
  int unsigned      fail_tally = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fail_tally++;
  endtask

  function automatic pool_result_t grant_or_release(input logic kind,
                                                    input logic [fbpa_pkg::IDX_W-1:0] idx);
    pool_result_t               r;
    logic [fbpa_pkg::CNT_W-1:0] size;
    logic [fbpa_pkg::IDX_W-1:0] c;
    logic                       ok;
    size = (cfg_chunks > fbpa_pkg::CNT_W'(fbpa_pkg::POOL_LIMIT)) ?
           fbpa_pkg::CNT_W'(fbpa_pkg::POOL_LIMIT) : cfg_chunks;
    r = '0;
    r.status = fbpa_pkg::STATUS_OK;
    if (kind == fbpa_pkg::KIND_ALLOC) begin
      ok = 1'b0;
      c = '0;
      if (live_cnt < size) begin
        if (stacked) begin
          c = stack_top;
          stack_top = link_mem[c];
          ok = 1'b1;
        end else if (fresh_ptr < size) begin
          c = fresh_ptr[fbpa_pkg::IDX_W-1:0];
          fresh_ptr = fresh_ptr + ONE;
          ok = 1'b1;
        end
      end
      if (ok) begin
        taken_bit[c] = 1'b1;
        live_cnt = live_cnt + ONE;
        if (live_cnt > peak_cnt) peak_cnt = live_cnt;
        stacked = (fresh_ptr > live_cnt);
        r.granted = c;
        r.near = (live_cnt >= cfg_warn);
      end else begin
        r.status = fbpa_pkg::STATUS_EXHAUSTED;
      end
    end else begin
      if ({1'b0, idx} >= size) begin
        r.status = fbpa_pkg::STATUS_RANGE;
      end else if (!taken_bit[idx] || live_cnt == '0) begin
        r.status = fbpa_pkg::STATUS_DOUBLE;
      end else begin
        taken_bit[idx] = 1'b0;
        link_mem[idx] = stack_top;
        stack_top = idx;
        live_cnt = live_cnt - ONE;
        stacked = (fresh_ptr > live_cnt);
      end
    end
    r.live = live_cnt;
    r.peak = peak_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_chunks = fbpa_pkg::CHUNK_COUNT_RST;
      cfg_warn   = fbpa_pkg::WARN_LEVEL_RST;
      for (int i = 0; i < fbpa_pkg::INDEX_SPACE; i++) begin
        link_mem[i]  = '0;
        taken_bit[i] = 1'b0;
      end
      stack_top = '0;
      stacked   = 1'b0;
      fresh_ptr = '0;
      live_cnt  = '0;
      peak_cnt  = '0;
      awaited_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = awaited_q.pop_front();
          if (rsp_mon.status !== want.status || rsp_mon.granted_index !== want.granted ||
              rsp_mon.live_count !== want.live || rsp_mon.peak_count !== want.peak ||
              rsp_mon.near_full !== want.near)
            report_mismatch($sformatf(
              "got/exp status %0d/%0d granted %0d/%0d live %0d/%0d peak %0d/%0d near %b/%b",
              rsp_mon.status, want.status, rsp_mon.granted_index, want.granted,
              rsp_mon.live_count, want.live, rsp_mon.peak_count, want.peak,
              rsp_mon.near_full, want.near));
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_q.push_back(grant_or_release(req_mon.kind, req_mon.chunk_index));
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == fbpa_pkg::REG_CHUNK_COUNT) cfg_chunks = pwdata[fbpa_pkg::CNT_W-1:0];
          else cfg_warn = pwdata[fbpa_pkg::CNT_W-1:0];
        end else begin
          want.live = (paddr[2] == fbpa_pkg::REG_CHUNK_COUNT) ? cfg_chunks : cfg_warn;
          if (prdata !== fbpa_pkg::DATA_W'(want.live))
            report_mismatch($sformatf("register read at %0h: got %0h exp %0h",
                                      paddr, prdata, want.live));
        end
      end
    end
    n_fail    <= fail_tally;
    n_pending <= awaited_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the pool allocator testbench: clock, reset, request and register stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [fbpa_pkg::ADDR_W-1:0] paddr;
  logic [fbpa_pkg::DATA_W-1:0] pwdata;
  logic [fbpa_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  int unsigned                 n_fail;
  int unsigned                 n_pending;

  bit gaps_on     = 1'b1;
  int stall_left  = 0;
  int beats_sent  = 0;
  int cur_size    = 256;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (req_ch),
    .out_if  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tb_pool_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (gaps_on && stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic kind, input logic [fbpa_pkg::IDX_W-1:0] idx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.chunk_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  task automatic alloc_req();
    send(fbpa_pkg::KIND_ALLOC, fbpa_pkg::IDX_W'($urandom));
  endtask

  task automatic free_req(input logic [fbpa_pkg::IDX_W-1:0] idx);
    send(fbpa_pkg::KIND_FREE, idx);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic reg_sel,
                            input logic [fbpa_pkg::CNT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= fbpa_pkg::ADDR_W'({reg_sel, 2'b00});
    pwdata  <= fbpa_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pool(input logic [fbpa_pkg::CNT_W-1:0] chunks,
                          input logic [fbpa_pkg::CNT_W-1:0] warn);
    drain();
    cfg_access(1'b1, fbpa_pkg::REG_CHUNK_COUNT, chunks);
    cfg_access(1'b1, fbpa_pkg::REG_WARN_LEVEL, warn);
    cfg_access(1'b0, fbpa_pkg::REG_CHUNK_COUNT, '0);
    cfg_access(1'b0, fbpa_pkg::REG_WARN_LEVEL, '0);
    cur_size = (chunks > fbpa_pkg::POOL_LIMIT) ? fbpa_pkg::POOL_LIMIT : int'(chunks);
  endtask

  task automatic sweep(input int n);
    int perm [fbpa_pkg::INDEX_SPACE];
    int j;
    int t;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < n; i++) free_req(fbpa_pkg::IDX_W'(perm[i]));
  endtask

  task automatic run_phase(input int budget, input int alloc_pct);
    int start;
    int pick;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 99) < alloc_pct) alloc_req();
        else if (cur_size > 0 && $urandom_range(0, 9) != 0)
          free_req(fbpa_pkg::IDX_W'($urandom_range(0, cur_size - 1)));
        else free_req(fbpa_pkg::IDX_W'($urandom));
      end else if (pick < 75) begin
        repeat (cur_size + 2) alloc_req();
      end else if (pick < 88) begin
        sweep(cur_size);
      end else if (pick < 96) begin
        free_req(fbpa_pkg::IDX_W'($urandom));
      end else begin
        drain();
      end
    end
    sweep(cur_size);
  endtask

  initial begin
    rst_n              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = fbpa_pkg::KIND_ALLOC;
    req_ch.chunk_index = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    free_req(8'd0);
    free_req(8'd255);
    repeat (3) alloc_req();
    free_req(8'd1);
    free_req(8'd1);
    alloc_req();
    free_req(8'd2);
    free_req(8'd0);
    repeat (3) alloc_req();
    set_pool(9'd4, 9'd2);
    alloc_req();
    free_req(8'd4);
    free_req(8'd3);
    free_req(8'd2);
    free_req(8'd1);
    set_pool(9'd2, 9'd511);
    free_req(8'd3);
    alloc_req();
    alloc_req();
    set_pool(9'd0, 9'd0);
    alloc_req();
    free_req(8'd0);
    set_pool(9'd300, 9'd0);
    repeat (3) alloc_req();
    sweep(8);

    set_pool(9'd1, 9'd0);
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(55, 60);
    set_pool(9'd1, 9'd1);
    run_phase(55, 50);
    set_pool(9'd2, 9'd2);
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(55, 55);
    set_pool(9'd3, 9'd511);
    run_phase(55, 65);
    set_pool(9'd5, 9'd256);
    gaps_on = 1'b0;
    run_phase(55, 50);
    set_pool(9'd8, 9'd7);
    gaps_on = 1'b1;
    run_phase(55, 60);
    set_pool(9'd0, 9'd5);
    run_phase(40, 50);
    set_pool(fbpa_pkg::CNT_W'($urandom_range(1, 24)), fbpa_pkg::CNT_W'($urandom_range(0, 26)));
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(55, 55);
    set_pool(9'd16, 9'd14);
    run_phase(55, 70);
    set_pool(fbpa_pkg::CNT_W'($urandom_range(1, 24)), fbpa_pkg::CNT_W'($urandom_range(0, 26)));
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(55, 45);
    set_pool(9'd32, 9'd29);
    gaps_on = 1'b1;
    run_phase(55, 65);

    set_pool(9'd256, 9'd231);
    repeat (258) alloc_req();
    repeat (30) begin
      if ($urandom_range(0, 1) == 0) alloc_req();
      else free_req(fbpa_pkg::IDX_W'($urandom));
    end
    sweep(256);

    gaps_on = 1'b0;
    set_pool(9'd6, 9'd4);
    run_phase(80, 55);

    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
